// ===== design/kdrs_pkg.sv =====
package kdrs_pkg;

    localparam logic [1:0] OP_SPLIT = 2'd0;
    localparam logic [1:0] OP_LEAF  = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [0:0] REG_NUM_DIMS   = 1'd0;
    localparam logic [0:0] REG_NUM_LEVELS = 1'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] address;
        logic [15:0] split_word;
        logic [11:0] leaf_last;
        logic [15:0] coord_a;
        logic [15:0] coord_b;
        logic [15:0] coord_c;
        logic [15:0] coord_d;
        logic [11:0] point_id;
        logic [15:0] radius;
        logic [33:0] radius_sq;
    } in_item_t;

    typedef struct packed {
        logic        last;
        logic [11:0] found_id;
        logic [15:0] found_a;
        logic [15:0] found_b;
        logic [15:0] found_c;
        logic [15:0] found_d;
        logic [33:0] dist_sq;
        logic [5:0]  match_count;
        logic        overflow;
    } out_item_t;

endpackage

// ===== design/kdrs_dist.sv =====
module kdrs_dist
(
    input  logic        clk,
    input  logic [15:0] p,
    input  logic [15:0] q,
    input  logic        en,
    output logic [31:0] sq_reg
);

    logic [15:0] diff;

    assign diff = (p > q) ? (p - q) : (q - p);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= diff * diff;
        end
    end

endmodule

// ===== design/kd_tree_range_search_unit.sv =====
// Range search over an implicit kd-tree held in on-chip memories.
// Input channel (in_valid/in_stall/in_data): write beats load split words,
// leaf bounds and points and give no result. A query beat walks the tree
// depth first and emits one out beat per match up to MAX_MATCHES, then a
// closing beat with last set, match count and overflow flag.
// Output channel (out_valid/out_stall/out_data) is a single register stage.
// Walk: an interior node steps through pop and split compare, and a leaf
// through pop and two bound reads; each point scanned then steps through
// S_PT, S_PT2, S_PT3 and S_EMIT, paced by the registered memory reads and
// the registered distance, and a final S_PT closes its scan. The closing
// beat is loaded in S_DONE after the final pop finds the stack empty.
// Queries run one at a time; in_stall is held while one is in progress.
// A stalled output holds the walk until its beat is taken; no match is lost.
// Reset clears the control state and the stack and sets num_dims to 2 and
// num_levels to 10. Tables are undefined until written.
// Configuration (cfg_we/cfg_index/cfg_data) must be written by the user only when idle; the block does not enforce it.
module kd_tree_range_search_unit #(
    parameter int MAX_POINTS  = 4096,
    parameter int MAX_LEVELS  = 10,
    parameter int MAX_MATCHES = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  kdrs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output kdrs_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data
);

    localparam int LEAF_N = 1 << (MAX_LEVELS - 1);
    localparam int NW     = (MAX_LEVELS < 2) ? 1 : MAX_LEVELS;
    localparam int LW     = (MAX_LEVELS < 2) ? 1 : MAX_LEVELS - 1;
    localparam int PW     = (MAX_POINTS < 2) ? 1 : $clog2(MAX_POINTS);
    localparam int PW1    = PW + 1;
    localparam int SD     = 16;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_NODE  = 4'd2;
    localparam logic [3:0] S_LEAF  = 4'd3;
    localparam logic [3:0] S_LEAF2 = 4'd4;
    localparam logic [3:0] S_PT    = 4'd5;
    localparam logic [3:0] S_PT2   = 4'd6;
    localparam logic [3:0] S_PT3   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [15:0]     split_mem [LEAF_N];
    logic [11:0]     leaf_mem  [LEAF_N];
    logic [63:0]     pt_mem    [MAX_POINTS];
    logic [11:0]     id_mem    [MAX_POINTS];

    logic [NW-1:0]   stack_reg [SD];
    logic [4:0]      sp_reg;
    logic [3:0]      state_reg;
    logic [2:0]      dims_reg;
    logic [3:0]      levels_reg;
    kdrs_pkg::in_item_t q_reg;
    logic [NW-1:0]   node_reg;
    logic [15:0]     split_rd;
    logic [11:0]     leaf_rd;
    logic [63:0]     pt_rd;
    logic [11:0]     id_rd;
    logic [PW1-1:0]  j_reg;
    logic [PW1-1:0]  hi_reg;
    logic [5:0]      count_reg;
    logic            over_reg;
    logic            out_valid_reg;
    kdrs_pkg::out_item_t out_reg;
    logic [31:0]     sq0, sq1, sq2, sq3;
    logic [33:0]     dsq;
    logic [2:0]      dims;
    logic [3:0]      levels;
    logic [NW-1:0]   ninterior;
    logic [LW-1:0]   leaf_idx;
    logic [LW-1:0]   leaf_prev;
    logic [NW-1:0]   top_node;
    logic [NW-1:0]   rd_node;
    logic [LW-1:0]   rd_leaf;
    logic [15:0]     qd;
    logic [15:0]     loc;
    logic            take;
    logic            out_free;
    logic            out_load;

    assign dims      = (dims_reg == 3'd0) ? 3'd1 : ((dims_reg > 3'd4) ? 3'd4 : dims_reg);
    assign levels    = (levels_reg == 4'd0) ? 4'd1 :
                       ((int'(levels_reg) > MAX_LEVELS) ? 4'(MAX_LEVELS) : levels_reg);
    assign ninterior = NW'((NW+1)'(1) << (levels - 4'd1)) - NW'(1);
    assign leaf_idx  = LW'(node_reg - ninterior);
    assign leaf_prev = leaf_idx - LW'(1);
    assign top_node  = stack_reg[4'(sp_reg - 5'd1)];
    assign rd_node   = (state_reg == S_POP) ? top_node : node_reg;
    assign rd_leaf   = LW'(rd_node - ninterior);
    assign take      = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = out_free &&
                       ((state_reg == S_EMIT && dsq < q_reg.radius_sq &&
                         count_reg < 6'(MAX_MATCHES)) ||
                        state_reg == S_DONE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign loc       = {split_rd[15:2], 2'b00};

    always_comb
    begin
        case (split_rd[1:0])
            2'd0: qd = q_reg.coord_a;
            2'd1: qd = q_reg.coord_b;
            2'd2: qd = q_reg.coord_c;
            default: qd = q_reg.coord_d;
        endcase
    end

    kdrs_dist u_d0 (.clk(clk), .p(pt_rd[15:0]),  .q(q_reg.coord_a), .en(1'b1), .sq_reg(sq0));
    kdrs_dist u_d1 (.clk(clk), .p(pt_rd[31:16]), .q(q_reg.coord_b), .en(1'b1), .sq_reg(sq1));
    kdrs_dist u_d2 (.clk(clk), .p(pt_rd[47:32]), .q(q_reg.coord_c), .en(1'b1), .sq_reg(sq2));
    kdrs_dist u_d3 (.clk(clk), .p(pt_rd[63:48]), .q(q_reg.coord_d), .en(1'b1), .sq_reg(sq3));

    assign dsq = 34'(sq0)
               + ((dims > 3'd1) ? 34'(sq1) : 34'd0)
               + ((dims > 3'd2) ? 34'(sq2) : 34'd0)
               + ((dims > 3'd3) ? 34'(sq3) : 34'd0);

    // memories
    always_ff @(posedge clk)
    begin
        if (take && in_data.operation == kdrs_pkg::OP_SPLIT &&
            int'(in_data.address) < LEAF_N - 1)
        begin
            split_mem[LW'(in_data.address)] <= in_data.split_word;
        end
        if (take && in_data.operation == kdrs_pkg::OP_LEAF &&
            int'(in_data.address) < LEAF_N)
        begin
            leaf_mem[LW'(in_data.address)] <= in_data.leaf_last;
        end
        if (take && in_data.operation == kdrs_pkg::OP_POINT &&
            int'(in_data.address) < MAX_POINTS)
        begin
            pt_mem[PW'(in_data.address)] <= {in_data.coord_d, in_data.coord_c,
                                             in_data.coord_b, in_data.coord_a};
            id_mem[PW'(in_data.address)] <= in_data.point_id;
        end
        split_rd <= split_mem[LW'(rd_node)];
        if (state_reg == S_LEAF)
        begin
            leaf_rd <= leaf_mem[leaf_prev];
        end
        else
        begin
            leaf_rd <= leaf_mem[rd_leaf];
        end
        pt_rd <= pt_mem[PW'(j_reg)];
        id_rd <= id_mem[PW'(j_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            dims_reg      <= 3'd2;
            levels_reg    <= 4'd10;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            node_reg      <= '0;
            j_reg         <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            over_reg      <= 1'b0;
            for (int i = 0; i < SD; i++)
            begin
                stack_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == kdrs_pkg::REG_NUM_DIMS)
                begin
                    dims_reg <= cfg_data[2:0];
                end
                else
                begin
                    levels_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take && in_data.operation == kdrs_pkg::OP_QUERY)
                    begin
                        stack_reg[0] <= '0;
                        sp_reg       <= 5'd1;
                        count_reg    <= '0;
                        over_reg     <= 1'b0;
                        state_reg    <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (sp_reg == 5'd0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        node_reg  <= top_node;
                        sp_reg    <= sp_reg - 5'd1;
                        state_reg <= (top_node < ninterior) ? S_NODE : S_LEAF;
                    end
                end
                S_NODE:
                begin
                    // split_rd now valid; push near, then far when far_ok
                    begin
                        logic          near_left;
                        logic          far_ok;
                        logic [NW-1:0] nl;
                        logic [NW-1:0] nr;
                        logic [4:0]    sp1;
                        near_left = ({1'b0, qd} < {1'b0, loc});
                        far_ok    = near_left ? ((loc - qd) <= q_reg.radius)
                                              : ((qd - loc) < q_reg.radius);
                        nl        = NW'({node_reg, 1'b1});
                        nr        = NW'({node_reg, 1'b0}) + NW'(2);
                        sp1       = sp_reg;
                        if (sp1 < 5'(SD))
                        begin
                            stack_reg[4'(sp1)] <= near_left ? nl : nr;
                            sp1 = sp1 + 5'd1;
                        end
                        if (far_ok && sp1 < 5'(SD))
                        begin
                            stack_reg[4'(sp1)] <= near_left ? nr : nl;
                            sp1 = sp1 + 5'd1;
                        end
                        sp_reg    <= sp1;
                        state_reg <= S_POP;
                    end
                end
                S_LEAF:
                begin
                    hi_reg    <= (leaf_rd > 12'(MAX_POINTS - 1)) ? PW1'(MAX_POINTS - 1)
                                                               : PW1'(leaf_rd);
                    state_reg <= S_LEAF2;
                end
                S_LEAF2:
                begin
                    j_reg     <= (leaf_idx == '0) ? '0 : PW1'(leaf_rd) + PW1'(1);
                    state_reg <= S_PT;
                end
                S_PT:
                begin
                    state_reg <= (j_reg > hi_reg) ? S_POP : S_PT2;
                end
                S_PT2:
                begin
                    state_reg <= S_PT3;
                end
                S_PT3:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (dsq < q_reg.radius_sq)
                    begin
                        if (count_reg < 6'(MAX_MATCHES))
                        begin
                            if (out_free)
                            begin
                                out_reg.last         <= 1'b0;
                                out_reg.found_id     <= id_rd;
                                out_reg.found_a      <= pt_rd[15:0];
                                out_reg.found_b      <= (dims > 3'd1) ? pt_rd[31:16] : 16'd0;
                                out_reg.found_c      <= (dims > 3'd2) ? pt_rd[47:32] : 16'd0;
                                out_reg.found_d      <= (dims > 3'd3) ? pt_rd[63:48] : 16'd0;
                                out_reg.dist_sq      <= dsq;
                                out_reg.match_count  <= '0;
                                out_reg.overflow     <= 1'b0;
                                count_reg            <= count_reg + 6'd1;
                                j_reg                <= j_reg + PW1'(1);
                                state_reg            <= S_PT;
                            end
                        end
                        else
                        begin
                            over_reg  <= 1'b1;
                            j_reg     <= j_reg + PW1'(1);
                            state_reg <= S_PT;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + PW1'(1);
                        state_reg <= S_PT;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.last        <= 1'b1;
                        out_reg.found_id    <= '0;
                        out_reg.found_a     <= '0;
                        out_reg.found_b     <= '0;
                        out_reg.found_c     <= '0;
                        out_reg.found_d     <= '0;
                        out_reg.dist_sq     <= '0;
                        out_reg.match_count <= count_reg;
                        out_reg.overflow    <= over_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/kdrs_checker.sv =====
module kdrs_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  kdrs_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  kdrs_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("out beat changed while stalled");

    a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.match_count == 6'd0 && !out_data.overflow)
        else $error("match beat carries summary fields");

    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.dist_sq == 34'd0 && out_data.found_id == 12'd0)
        else $error("summary beat carries match fields");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.operation == kdrs_pkg::OP_QUERY |=> in_stall)
        else $error("input taken during query");

endmodule

bind kd_tree_range_search_unit kdrs_checker u_kdrs_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
